// ===== sv/psr_pkg.sv =====
// Shared constants, codes and control types of the packet sequence reorderer.
`timescale 1ns / 1ps

package psr_pkg;

    localparam int HOLD_DEPTH = 32;
    localparam int SEQ_W      = 32;
    localparam int HANDLE_W   = 16;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int MAXH_W     = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    typedef logic [1:0] t_status;
    localparam t_status ST_DUPLICATE = 2'd0;
    localparam t_status ST_DELIVERED = 2'd1;
    localparam t_status ST_HELD      = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_HELD  = 1'd0;
    localparam t_cfg_idx CFG_START_SEQ = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic load_in;       // capture the arriving item
        logic eval;          // classify the captured item
        logic drain;         // emit pending delivery, fetch next in run
        logic sel_expected;  // slot match key is the expected sequence
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic diff_zero;
        logic out_free;
        logic drain_hit;
    } t_dp_status;

endpackage

// ===== sv/psr_ctrl.sv =====
// Control state machine of the packet sequence reorderer.
`timescale 1ns / 1ps

module psr_ctrl
    import psr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output t_ctl_cmd   o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.sel_expected = (r_state == S_DRAIN);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                // an in-order packet emits nothing yet: its last flag needs the drain lookup
                if (i_status.diff_zero) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_DRAIN;
                end else if (i_status.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.drain = 1'b1;
                    if (!i_status.drain_hit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== sv/psr_datapath.sv =====
// Datapath of the packet sequence reorderer: slot store, expected sequence, result register.
`timescale 1ns / 1ps

module psr_datapath
    import psr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl_cmd              i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SEQ_W-1:0]      i_seq_number,
    input  logic [HANDLE_W-1:0]   i_buf_handle,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_status               o_status_code,
    output logic [SEQ_W-1:0]      o_out_seq,
    output logic [HANDLE_W-1:0]   o_out_handle,
    output logic                  o_last
);

    logic [SEQ_W-1:0]      r_seq;
    logic [HANDLE_W-1:0]   r_handle;
    logic [SEQ_W-1:0]      r_expected;
    logic [MAXH_W-1:0]     r_max_held;
    logic [HOLD_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]      r_count;
    logic [SEQ_W-1:0]      r_slot_seq    [HOLD_DEPTH];
    logic [HANDLE_W-1:0]   r_slot_handle [HOLD_DEPTH];
    logic [SEQ_W-1:0]      r_pend_seq;
    logic [HANDLE_W-1:0]   r_pend_handle;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SEQ_W-1:0]      r_out_seq;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic                  r_out_last;

    logic [SEQ_W-1:0]      key;
    logic [HOLD_DEPTH-1:0] match;
    logic [HOLD_DEPTH-1:0] free_oh;
    logic [HANDLE_W-1:0]   match_handle;
    logic [SEQ_W-1:0]      diff;
    logic                  hit;
    logic                  no_room;
    logic                  out_free;

    assign key = i_cmd.sel_expected ? r_expected : r_seq;

    always_comb begin
        match_handle = '0;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            match[i] = r_valid[i] && (r_slot_seq[i] == key);
            match_handle = match_handle | (r_slot_handle[i] & {HANDLE_W{match[i]}});
        end
    end

    assign hit      = |match;
    // lowest clear bit of the valid vector
    assign free_oh  = ~r_valid & (r_valid + HOLD_DEPTH'(1));
    assign diff     = r_seq - r_expected;
    assign no_room  = (&r_valid)
                   || (32'(r_count) >= 32'(r_max_held))
                   || (32'(r_count) >= 32'(HOLD_DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.diff_zero = (diff == '0);
    assign o_status.out_free  = out_free;
    assign o_status.drain_hit = hit;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= '0;
            r_max_held  <= MAXH_W'(32);
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result takes the output register the cycle the old one leaves
            if (i_cmd.drain || (i_cmd.eval && diff != '0)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_HELD: r_max_held <= i_cfg_data[MAXH_W-1:0];
                    CFG_START_SEQ: begin
                        r_expected <= i_cfg_data[SEQ_W-1:0];
                        r_valid    <= '0;
                        r_count    <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                if (diff[SEQ_W-1]) begin
                end else if (diff == '0) begin
                    r_valid    <= r_valid & ~match;
                    r_count    <= r_count - CNT_W'(hit);
                    r_expected <= r_expected + SEQ_W'(1);
                end else begin
                    if (!hit && !no_room) begin
                        r_valid <= r_valid | free_oh;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
            end
            if (i_cmd.drain) begin
                if (hit) begin
                    r_valid    <= r_valid & ~match;
                    r_count    <= r_count - CNT_W'(1);
                    r_expected <= r_expected + SEQ_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_seq    <= i_seq_number;
            r_handle <= i_buf_handle;
        end
        if (i_cmd.eval) begin
            // an in-order item leaves a stalled result in the output register alone
            if (diff != '0) begin
                r_out_seq    <= '0;
                r_out_handle <= '0;
                r_out_last   <= 1'b1;
            end
            r_pend_seq    <= r_seq;
            r_pend_handle <= r_handle;
            if (diff[SEQ_W-1]) begin
                r_out_status <= ST_DUPLICATE;
            end else if (diff != '0) begin
                r_out_status <= (!hit && no_room) ? ST_FULL : ST_HELD;
                for (int i = 0; i < HOLD_DEPTH; i++) begin
                    if (free_oh[i] && !hit && !no_room) begin
                        r_slot_seq[i]    <= r_seq;
                        r_slot_handle[i] <= r_handle;
                    end
                end
            end
        end
        if (i_cmd.drain) begin
            r_out_status <= ST_DELIVERED;
            r_out_seq    <= r_pend_seq;
            r_out_handle <= r_pend_handle;
            r_out_last   <= !hit;
            if (hit) begin
                r_pend_seq    <= r_expected;
                r_pend_handle <= match_handle;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status_code = r_out_status;
    assign o_out_seq     = r_out_seq;
    assign o_out_handle  = r_out_handle;
    assign o_last        = r_out_last;

    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_valid))
        else $error("held count out of step with slot valid bits");

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("sequence held in more than one slot");

    a_drain_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.drain && hit && !i_cfg_we) |=> (r_expected == $past(r_expected) + SEQ_W'(1)))
        else $error("drain step did not advance expected sequence");

endmodule

// ===== sv/packet_sequence_reorderer_top.sv =====
// A duplicate, held or full result is registered in the evaluate state after its item is
// captured; an in-order item's first delivery is registered by the drain state that follows.
// Output stalls hold both. The input stalls until the previous item is done: an in-order
// item stays in the drain state, one slot compare per delivery, until its run ends.
// Reset (synchronous, active low): expected sequence 0, max held 32, store empty,
// no result pending. Writing start_sequence empties the store at once.
`timescale 1ns / 1ps

module packet_sequence_reorderer_top
    import psr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SEQ_W-1:0]      i_seq_number,
    input  logic [HANDLE_W-1:0]   i_buf_handle,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_status               o_status,
    output logic [SEQ_W-1:0]      o_out_seq,
    output logic [HANDLE_W-1:0]   o_out_handle,
    output logic                  o_last
);

    t_ctl_cmd   cmd;
    t_dp_status dp_status;

    psr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (dp_status)
    );

    psr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (dp_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_seq_number  (i_seq_number),
        .i_buf_handle  (i_buf_handle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status_code (o_status),
        .o_out_seq     (o_out_seq),
        .o_out_handle  (o_out_handle),
        .o_last        (o_last)
    );

endmodule

// ===== tb/packet_sequence_reorderer_top_tb.sv =====
// Self-checking testbench of the packet sequence reorderer: directed table, then random phases.
`timescale 1ns / 1ps

module packet_sequence_reorderer_top_tb;
    import psr_pkg::*;

    typedef struct packed {
        t_status             st;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] hdl;
        logic                last;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] word;   // sequence number or register data
        logic [HANDLE_W-1:0]   hdl;
        logic                  typed;  // answer written in the row
        t_result               want;
    } t_step;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURSTY} t_stall_mode;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    t_cfg_idx              i_cfg_index  = CFG_MAX_HELD;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [SEQ_W-1:0]      i_seq_number = '0;
    logic [HANDLE_W-1:0]   i_buf_handle = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    t_status               o_status;
    logic [SEQ_W-1:0]      o_out_seq;
    logic [HANDLE_W-1:0]   o_out_handle;
    logic                  o_last;

    packet_sequence_reorderer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_seq_number (i_seq_number),
        .i_buf_handle (i_buf_handle),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_seq    (o_out_seq),
        .o_out_handle (o_out_handle),
        .o_last       (o_last)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the reorder state
    logic [SEQ_W-1:0]    next_seq;
    logic [MAXH_W-1:0]   held_limit;
    logic                held_valid [HOLD_DEPTH];
    logic [SEQ_W-1:0]    held_seq   [HOLD_DEPTH];
    logic [HANDLE_W-1:0] held_hdl   [HOLD_DEPTH];

    t_result     fresh_results[$];    // answers to the item just accepted
    t_result     awaited_results[$];  // answers not yet seen at the output
    t_result     front;
    t_stall_mode stall_mode = STALL_NONE;
    logic [3:0]  stall_tick = '0;
    bit          gaps_on    = 1'b0;
    int          burst_left = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int          longest_run = 0;
    int          mismatches = 0;

    function automatic void store_reset();
        next_seq   = '0;
        held_limit = MAXH_W'(HOLD_DEPTH);
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            held_valid[i] = 1'b0;
            held_seq[i]   = '0;
            held_hdl[i]   = '0;
        end
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_MAX_HELD) begin
            held_limit = data[MAXH_W-1:0];
        end else if (idx == CFG_START_SEQ) begin
            next_seq = data[SEQ_W-1:0];
            for (int i = 0; i < HOLD_DEPTH; i++) held_valid[i] = 1'b0;
        end
    endfunction

    function automatic int find_held(input logic [SEQ_W-1:0] seq);
        for (int i = 0; i < HOLD_DEPTH; i++)
            if (held_valid[i] && held_seq[i] == seq) return i;
        return -1;
    endfunction

    function automatic t_result answer(input t_status st, input logic [SEQ_W-1:0] seq,
                                       input logic [HANDLE_W-1:0] hdl, input logic last);
        t_result r;
        r.st = st;
        r.seq = seq;
        r.hdl = hdl;
        r.last = last;
        return r;
    endfunction

    // Fills fresh_results with the answers to one item and updates the shadow state.
    function automatic void reorder_item(input logic [SEQ_W-1:0] seq,
                                         input logic [HANDLE_W-1:0] hdl);
        logic [SEQ_W-1:0] seq_gap;
        t_result r;
        int hit;
        int count;
        int free_idx;
        int cap;
        fresh_results.delete();
        seq_gap = seq - next_seq;
        if (seq_gap[SEQ_W-1]) begin
            fresh_results.push_back(answer(ST_DUPLICATE, '0, '0, 1'b1));
        end else if (seq_gap == '0) begin
            hit = find_held(seq);
            if (hit >= 0) held_valid[hit] = 1'b0;
            next_seq = next_seq + 1'b1;
            r = answer(ST_DELIVERED, seq, hdl, 1'b0);
            // drain the held run that now continues without a gap
            forever begin
                hit = find_held(next_seq);
                if (hit < 0) break;
                fresh_results.push_back(r);
                held_valid[hit] = 1'b0;
                r = answer(ST_DELIVERED, held_seq[hit], held_hdl[hit], 1'b0);
                next_seq = next_seq + 1'b1;
            end
            r.last = 1'b1;
            fresh_results.push_back(r);
        end else if (find_held(seq) >= 0) begin
            fresh_results.push_back(answer(ST_HELD, '0, '0, 1'b1));
        end else begin
            count = 0;
            free_idx = -1;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (held_valid[i]) count++;
                else if (free_idx < 0) free_idx = i;
            end
            cap = (int'(held_limit) < HOLD_DEPTH) ? int'(held_limit) : HOLD_DEPTH;
            if (count >= cap || free_idx < 0) begin
                fresh_results.push_back(answer(ST_FULL, '0, '0, 1'b1));
            end else begin
                held_valid[free_idx] = 1'b1;
                held_seq[free_idx]   = seq;
                held_hdl[free_idx]   = hdl;
                fresh_results.push_back(answer(ST_HELD, '0, '0, 1'b1));
            end
        end
    endfunction

    function automatic t_step item_row(input logic [SEQ_W-1:0] seq, input logic [HANDLE_W-1:0] hdl);
        t_step s;
        s = '0;
        s.kind = ROW_ITEM;
        s.word = seq;
        s.hdl  = hdl;
        return s;
    endfunction

    function automatic t_step item_chk(input logic [SEQ_W-1:0] seq, input logic [HANDLE_W-1:0] hdl,
                                       input t_status st, input logic [SEQ_W-1:0] oseq,
                                       input logic [HANDLE_W-1:0] ohdl);
        t_step s;
        s = item_row(seq, hdl);
        s.typed = 1'b1;
        s.want  = answer(st, oseq, ohdl, 1'b1);
        return s;
    endfunction

    function automatic t_step cfg_row(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_step s;
        s = '0;
        s.kind = ROW_CFG;
        s.idx  = idx;
        s.word = data;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, what, got, want);
    endtask

    // Waits for every answer, then idles on in case a drain is still winding down.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        reg_writes++;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_step(input t_step s);
        int gap;
        if (s.kind == ROW_CFG) begin
            write_reg(s.idx, s.word);
        end else begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = gaps_on ? $urandom_range(0, 5) : 0;
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            i_in_valid   <= 1'b1;
            i_seq_number <= s.word[SEQ_W-1:0];
            i_buf_handle <= s.hdl;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            items_sent++;
            reorder_item(s.word[SEQ_W-1:0], s.hdl);
            if (fresh_results.size() > longest_run) longest_run = fresh_results.size();
            if (s.typed) awaited_results.push_back(s.want);
            else foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
        end
    endtask

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= ($urandom_range(0, 3) == 0);
            default:      i_out_stall <= (stall_tick >= 4'd10);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("with nothing pending, status", SEQ_W'(o_status), '0);
            end else begin
                front = awaited_results.pop_front();
                if (o_status !== front.st)
                    report_mismatch("status", SEQ_W'(o_status), SEQ_W'(front.st));
                if (o_out_seq !== front.seq)
                    report_mismatch("out_seq", o_out_seq, front.seq);
                if (o_out_handle !== front.hdl)
                    report_mismatch("out_handle", SEQ_W'(o_out_handle), SEQ_W'(front.hdl));
                if (o_last !== front.last)
                    report_mismatch("last", SEQ_W'(o_last), SEQ_W'(front.last));
            end
            results_seen++;
        end
    end

    initial begin
        #3_000_000;
        $display("packet_sequence_reorderer_top_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_step                 steps[$];
        logic [CFG_DATA_W-1:0] maxh_word [5];
        logic [CFG_DATA_W-1:0] start_word [5];
        t_stall_mode           phase_stall [5];
        bit                    phase_gaps [5];
        int                    win [40];
        int                    n;
        int                    j;
        int                    tmp;
        int                    phase_first;
        logic [SEQ_W-1:0]      base;

        store_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: wrap, half range, repeats, capacity limits, multi-item drains
        steps.push_back(item_chk(32'h0000_0000, 16'hFFFF, ST_DELIVERED, 32'h0, 16'hFFFF));
        steps.push_back(item_chk(32'h0000_0000, 16'h1234, ST_DUPLICATE, '0, '0));
        steps.push_back(item_chk(32'h8000_0001, 16'h0000, ST_DUPLICATE, '0, '0));
        steps.push_back(item_chk(32'h8000_0000, 16'h8000, ST_HELD, '0, '0));
        steps.push_back(item_chk(32'h0000_0003, 16'h0003, ST_HELD, '0, '0));
        steps.push_back(item_chk(32'h0000_0003, 16'h1234, ST_HELD, '0, '0));
        steps.push_back(item_chk(32'h0000_0002, 16'h0002, ST_HELD, '0, '0));
        steps.push_back(item_row(32'h0000_0001, 16'h0000));
        steps.push_back(cfg_row(CFG_MAX_HELD, 32'd2));
        steps.push_back(item_chk(32'h0000_0006, 16'h0006, ST_HELD, '0, '0));
        steps.push_back(item_chk(32'h0000_0007, 16'h0007, ST_FULL, '0, '0));
        steps.push_back(cfg_row(CFG_MAX_HELD, 32'd0));
        steps.push_back(item_chk(32'h0000_0008, 16'h0008, ST_FULL, '0, '0));
        steps.push_back(item_chk(32'h0000_0004, 16'hFFFF, ST_DELIVERED, 32'h4, 16'hFFFF));
        steps.push_back(cfg_row(CFG_START_SEQ, 32'hFFFF_FFFF));
        steps.push_back(cfg_row(CFG_MAX_HELD, 32'd63));
        steps.push_back(item_chk(32'h0000_0000, 16'h5555, ST_HELD, '0, '0));
        steps.push_back(item_row(32'hFFFF_FFFF, 16'hAAAA));
        steps.push_back(item_chk(32'hFFFF_FFFE, 16'h0000, ST_DUPLICATE, '0, '0));
        steps.push_back(item_chk(32'h8000_0000, 16'h7FFF, ST_HELD, '0, '0));
        steps.push_back(item_chk(32'h8000_0001, 16'hFFFF, ST_DUPLICATE, '0, '0));
        steps.push_back(item_chk(32'h0000_0001, 16'h0000, ST_DELIVERED, 32'h1, 16'h0000));

        stall_mode = STALL_RANDOM;
        gaps_on    = 1'b1;
        foreach (steps[i]) run_step(steps[i]);

        // random phases; upper data bits on one max_held write must be ignored
        maxh_word   = '{32'd32, 32'hABCD_EF03, 32'd63, 32'd0, 32'd32};
        start_word  = '{$urandom, 32'hFFFF_FFF8, $urandom, $urandom, 32'h7FFF_FFFC};
        phase_stall = '{STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_RANDOM, STALL_BURSTY};
        phase_gaps  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_MAX_HELD, maxh_word[p]);
            write_reg(CFG_START_SEQ, start_word[p]);
            stall_mode  = phase_stall[p];
            gaps_on     = phase_gaps[p];
            phase_first = items_sent;
            if (p == 2) begin
                // fill the whole store, overflow it, then release all 33 in one run
                base = next_seq;
                for (int k = 0; k < HOLD_DEPTH; k++) win[k] = k + 1;
                for (int k = HOLD_DEPTH - 1; k > 0; k--) begin
                    j = $urandom_range(0, k);
                    tmp = win[k];
                    win[k] = win[j];
                    win[j] = tmp;
                end
                for (int k = 0; k < HOLD_DEPTH; k++)
                    run_step(item_row(base + win[k], HANDLE_W'($urandom)));
                run_step(item_row(base + 33, HANDLE_W'($urandom)));
                run_step(item_row(base + 34, HANDLE_W'($urandom)));
                run_step(item_row(base, HANDLE_W'($urandom)));
                run_step(item_row(base + 33, HANDLE_W'($urandom)));
            end else begin
                while (items_sent - phase_first < 12) begin
                    if (p == 4 && items_sent - phase_first >= 6 && held_limit != 1)
                        write_reg(CFG_MAX_HELD, 32'd1);
                    n = $urandom_range(2, 8);
                    for (int k = 0; k < n; k++) win[k] = k;
                    for (int k = n - 1; k > 0; k--) begin
                        j = $urandom_range(0, k);
                        tmp = win[k];
                        win[k] = win[j];
                        win[j] = tmp;
                    end
                    // sometimes leave a hole so held packets linger
                    if ($urandom_range(0, 5) == 0) n--;
                    base = next_seq;
                    for (int k = 0; k < n; k++) begin
                        run_step(item_row(base + win[k], HANDLE_W'($urandom)));
                        if ($urandom_range(0, 4) == 0)
                            run_step(item_row(base + win[$urandom_range(0, k)],
                                              HANDLE_W'($urandom)));
                        if ($urandom_range(0, 9) == 0)
                            run_step(item_row($urandom, HANDLE_W'($urandom)));
                    end
                end
            end
        end

        wait_idle();
        $display("packet_sequence_reorderer_top_tb: %0d items sent, %0d results compared",
                 items_sent, results_seen);
        $display("packet_sequence_reorderer_top_tb: %0d register writes, longest drain %0d, %0d %s",
                 reg_writes, longest_run, mismatches, "mismatches");
        if (mismatches == 0) begin
            $display("packet_sequence_reorderer_top_tb: done, clean");
        end else begin
            $display("packet_sequence_reorderer_top_tb: done, errors");
        end
        $finish;
    end

endmodule
